>>> hw/rtl/periodic_task_release_scheduler_core_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the periodic task release scheduler
// Each macro expands to a concurrent assertion, or to nothing with ASSERT_OFF.
// ----------------------------------------------------------------------------
`ifndef PERIODIC_TASK_RELEASE_SCHEDULER_CORE_DEFINES_SVH
`define PERIODIC_TASK_RELEASE_SCHEDULER_CORE_DEFINES_SVH
`ifndef ASSERT_OFF
// prop must hold at every clock edge out of reset
`define PTS_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);
// cons must hold in the cycle after ante
`define PTS_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) else $error(msg);
`else
`define PTS_ASSERT(lbl, clk, rstn, prop, msg)
`define PTS_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif
`endif

>>> hw/rtl/pts_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pts_pkg
// Shared constants, types and word layouts of the task release scheduler.
// ----------------------------------------------------------------------------
package pts_pkg;

    localparam int NUM_SLOTS = 8;
    localparam int IDX_W     = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

    localparam int OP_W   = 3;
    localparam int SLOT_W = 4;
    localparam int TID_W  = 16;
    localparam int PER_W  = 16;
    localparam int PEND_W = 8;
    localparam int SOUT_W = 3;
    localparam int TICK_W = 32;

    localparam logic [PEND_W-1:0] PEND_MAX = '1;

    // input word: op, slot, task_id, period, enable_value
    localparam int IN_OP_LSB   = 0;
    localparam int IN_SLOT_LSB = IN_OP_LSB + OP_W;
    localparam int IN_TID_LSB  = IN_SLOT_LSB + SLOT_W;
    localparam int IN_PER_LSB  = IN_TID_LSB + TID_W;
    localparam int IN_EN_LSB   = IN_PER_LSB + PER_W;
    localparam int IN_BITS     = IN_EN_LSB + 1;
    localparam int IN_TDATA_W  = ((IN_BITS + 7) / 8) * 8;

    // output word: ok, slot_out, task_id_out, tick_count
    localparam int OUT_BITS    = 1 + SOUT_W + TID_W + TICK_W;
    localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;
    localparam int OUT_PAD_W   = OUT_TDATA_W - OUT_BITS;

    typedef enum logic [OP_W-1:0] {
        OP_TICK     = 3'd0,
        OP_ADD      = 3'd1,
        OP_RELEASE  = 3'd2,
        OP_ENABLE   = 3'd3,
        OP_DISPATCH = 3'd4,
        OP_FIND     = 3'd5
    } op_t;

    typedef struct packed {
        logic [TID_W-1:0]  task_id;
        logic [PER_W-1:0]  period;
        logic [PER_W-1:0]  countdown;
        logic [PEND_W-1:0] pending;
        logic              enabled;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    // controller -> datapath
    typedef struct packed {
        logic load;      // capture input word
        logic rd;        // issue one table read
        logic fin;       // finish: add write
        logic out_load;  // load result word
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic in_scan;    // word needs a walk over all slots
        logic in_single;  // word needs one read-modify-write
        logic scan_last;  // current read is the last one
    } sts_t;

endpackage

>>> hw/rtl/pts_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pts_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module pts_ram #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 8
) (
    input  logic                                     aclk,
    input  logic                                     wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [DATA_W-1:0]                        wr_data,
    input  logic                                     rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [DATA_W-1:0]                        rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> hw/rtl/pts_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pts_ctrl
// Sequencer: accept, slot walk, last evaluation, result hand-off.
// ----------------------------------------------------------------------------
module pts_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    output logic          m_tvalid,
    input  logic          m_tready,
    input  pts_pkg::sts_t sts,
    output pts_pkg::cmd_t cmd
);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_SCAN = 4'b0010,
        ST_EVAL = 4'b0100,
        ST_FIN  = 4'b1000
    } state_t;

    state_t state_reg, state_next;
    logic   m_tvalid_reg, m_tvalid_next;
    logic   out_free;

    assign out_free = !m_tvalid_reg || m_tready;

    always_comb begin
        state_next    = state_reg;
        cmd           = '0;
        s_tready      = 1'b0;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = (sts.in_scan || sts.in_single) ? ST_SCAN : ST_FIN;
                end
            end
            ST_SCAN: begin
                cmd.rd = 1'b1;
                if (sts.scan_last) begin
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL: begin
                state_next = ST_FIN;
            end
            ST_FIN: begin
                if (out_free) begin
                    cmd.fin       = 1'b1;
                    cmd.out_load  = 1'b1;
                    m_tvalid_next = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;

endmodule

>>> hw/rtl/pts_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pts_datapath
// Slot table, walk counter, per-slot update logic and result register.
// ----------------------------------------------------------------------------
`include "periodic_task_release_scheduler_core_defines.svh"

module pts_datapath (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic [pts_pkg::IN_TDATA_W-1:0]      s_tdata,
    output logic [pts_pkg::OUT_TDATA_W-1:0]     m_tdata,
    input  pts_pkg::cmd_t                       cmd,
    output pts_pkg::sts_t                       sts
);

    // input word fields
    pts_pkg::op_t                  in_op;
    logic [pts_pkg::SLOT_W-1:0]    in_slot;
    logic                          in_range;

    // captured word
    pts_pkg::op_t                  op_reg;
    logic [pts_pkg::IDX_W-1:0]     slot_idx_reg;
    logic                          range_reg;
    logic                          single_reg;
    logic [pts_pkg::TID_W-1:0]     tid_reg;
    logic [pts_pkg::PER_W-1:0]     per_reg;
    logic                          en_reg;

    // walk and evaluation
    logic [pts_pkg::IDX_W-1:0]     cnt_reg;
    logic [pts_pkg::IDX_W-1:0]     rd_addr;
    logic [pts_pkg::IDX_W-1:0]     eval_idx_reg;
    logic                          eval_v_reg;
    logic                          vq_reg;
    logic [pts_pkg::NUM_SLOTS-1:0] valid_reg;
    logic [pts_pkg::ENTRY_W-1:0]   rd_data;
    pts_pkg::entry_t               ent, upd;
    logic                          present;

    // write port
    logic                          wr_en;
    logic [pts_pkg::IDX_W-1:0]     wr_addr;
    pts_pkg::entry_t               wr_data;

    // result
    logic                          hit_reg, hit_set;
    logic [pts_pkg::SOUT_W-1:0]    sout_reg;
    logic [pts_pkg::TID_W-1:0]     tout_reg;
    logic [pts_pkg::TICK_W-1:0]    ticks_reg;
    logic [pts_pkg::OUT_TDATA_W-1:0] m_tdata_reg;
    logic                          ok;

    assign in_op    = pts_pkg::op_t'(s_tdata[pts_pkg::IN_OP_LSB +: pts_pkg::OP_W]);
    assign in_slot  = s_tdata[pts_pkg::IN_SLOT_LSB +: pts_pkg::SLOT_W];
    assign in_range = int'(in_slot) < pts_pkg::NUM_SLOTS;

    assign sts.in_scan   = (in_op == pts_pkg::OP_TICK) || (in_op == pts_pkg::OP_DISPATCH)
                        || (in_op == pts_pkg::OP_FIND);
    assign sts.in_single = ((in_op == pts_pkg::OP_RELEASE) || (in_op == pts_pkg::OP_ENABLE))
                        && in_range;
    assign sts.scan_last = single_reg || (cnt_reg == pts_pkg::IDX_W'(pts_pkg::NUM_SLOTS - 1));

    assign rd_addr = single_reg ? slot_idx_reg : cnt_reg;

    // never-written slots read as empty
    assign ent     = vq_reg ? pts_pkg::entry_t'(rd_data) : '0;
    assign present = ent.task_id != '0;

    always_comb begin
        upd     = ent;
        wr_en   = 1'b0;
        wr_addr = eval_idx_reg;
        hit_set = 1'b0;
        if (eval_v_reg) begin
            case (op_reg)
                pts_pkg::OP_TICK: begin
                    if (present && ent.enabled && ent.countdown != '0) begin
                        wr_en = 1'b1;
                        if (ent.countdown == pts_pkg::PER_W'(1)) begin
                            upd.countdown = ent.period;
                            if (ent.pending != pts_pkg::PEND_MAX) begin
                                upd.pending = ent.pending + 1'b1;
                            end
                        end else begin
                            upd.countdown = ent.countdown - 1'b1;
                        end
                    end
                end
                pts_pkg::OP_RELEASE: begin
                    if (present) begin
                        wr_en   = 1'b1;
                        hit_set = 1'b1;
                        if (ent.pending != pts_pkg::PEND_MAX) begin
                            upd.pending = ent.pending + 1'b1;
                        end
                    end
                end
                pts_pkg::OP_ENABLE: begin
                    wr_en       = 1'b1;
                    upd.enabled = en_reg;
                end
                pts_pkg::OP_DISPATCH: begin
                    if (!hit_reg && present && ent.enabled && ent.pending != '0) begin
                        wr_en       = 1'b1;
                        hit_set     = 1'b1;
                        upd.pending = ent.pending - 1'b1;
                    end
                end
                pts_pkg::OP_FIND: begin
                    if (!hit_reg && ent.task_id == tid_reg) begin
                        hit_set = 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end else if (cmd.fin && op_reg == pts_pkg::OP_ADD && range_reg) begin
            wr_en         = 1'b1;
            wr_addr       = slot_idx_reg;
            upd.task_id   = tid_reg;
            upd.period    = per_reg;
            upd.countdown = per_reg;
            upd.pending   = pts_pkg::PEND_W'(1);
            upd.enabled   = 1'b1;
        end
        wr_data = upd;
    end

    pts_ram #(
        .DATA_W (pts_pkg::ENTRY_W),
        .DEPTH  (pts_pkg::NUM_SLOTS)
    ) u_table (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (cmd.rd),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg  <= '0;
            eval_v_reg <= 1'b0;
            hit_reg    <= 1'b0;
            ticks_reg  <= '0;
        end else begin
            eval_v_reg <= cmd.rd;
            if (wr_en) begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (cmd.load) begin
                hit_reg <= 1'b0;
                if (in_op == pts_pkg::OP_TICK) begin
                    ticks_reg <= ticks_reg + 1'b1;
                end
            end else if (hit_set) begin
                hit_reg <= 1'b1;
            end
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg       <= in_op;
            slot_idx_reg <= pts_pkg::IDX_W'(in_slot);
            range_reg    <= in_range;
            single_reg   <= sts.in_single;
            tid_reg      <= s_tdata[pts_pkg::IN_TID_LSB +: pts_pkg::TID_W];
            per_reg      <= s_tdata[pts_pkg::IN_PER_LSB +: pts_pkg::PER_W];
            en_reg       <= s_tdata[pts_pkg::IN_EN_LSB];
            cnt_reg      <= '0;
            sout_reg     <= '0;
            tout_reg     <= '0;
        end else begin
            if (cmd.rd) begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            // release hits report no slot
            if (hit_set && op_reg != pts_pkg::OP_RELEASE) begin
                sout_reg <= pts_pkg::SOUT_W'(eval_idx_reg);
                if (op_reg == pts_pkg::OP_DISPATCH) begin
                    tout_reg <= ent.task_id;
                end
            end
        end
        if (cmd.rd) begin
            eval_idx_reg <= rd_addr;
            vq_reg       <= valid_reg[rd_addr];
        end
        if (cmd.out_load) begin
            m_tdata_reg <= {{pts_pkg::OUT_PAD_W{1'b0}}, ticks_reg, tout_reg, sout_reg, ok};
        end
    end

    assign ok = (op_reg == pts_pkg::OP_TICK)
             || ((op_reg == pts_pkg::OP_ADD) && range_reg)
             || ((op_reg == pts_pkg::OP_ENABLE) && range_reg)
             || hit_reg;

    assign m_tdata = m_tdata_reg;

    `PTS_ASSERT(a_no_rw_clash, aclk, aresetn, !(wr_en && cmd.rd) || (wr_addr != rd_addr), "table write and read hit the same slot")
    `PTS_ASSERT_NEXT(a_ticks_hold, aclk, aresetn, !(cmd.load && in_op == pts_pkg::OP_TICK), $stable(ticks_reg), "tick count moved without a tick word")
    `PTS_ASSERT_NEXT(a_hit_sticky, aclk, aresetn, hit_reg && !cmd.load, hit_reg, "hit lost before next word")

endmodule

>>> hw/rtl/periodic_task_release_scheduler_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// periodic_task_release_scheduler_core
// Fixed-priority periodic task release scheduler with a streaming interface.
// ----------------------------------------------------------------------------
// Each input word carries one command (tick, add, release, enable, dispatch,
// find) and produces exactly one result word. The slot table lives in a small
// RAM read one slot per cycle, and tick, dispatch and find walk every slot,
// release and enable read their one slot and update it, and add and rejected
// words go straight to the result. Per-slot valid bits cleared at reset make
// the whole table read as empty right away; no clearing pass runs.
// A new word is taken as soon as the core is idle, even while the previous
// result still waits in the output register.
module periodic_task_release_scheduler_core (
    input  logic                                aclk,
    input  logic                                aresetn,
    // input: op[2:0], slot[6:3], task_id[22:7], period[38:23], enable_value[39]
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [pts_pkg::IN_TDATA_W-1:0]      s_tdata,
    // result: ok[0], slot_out[3:1], task_id_out[19:4], tick_count[51:20], zero pad
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [pts_pkg::OUT_TDATA_W-1:0]     m_tdata
);

    pts_pkg::cmd_t cmd;
    pts_pkg::sts_t sts;

    // sequencer: idle -> slot walk -> last evaluation -> result hand-off
    pts_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // slot table, update logic, tick counter and result register
    pts_datapath u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tdata (s_tdata),
        .m_tdata (m_tdata),
        .cmd     (cmd),
        .sts     (sts)
    );

endmodule
